// File: rtl/sbfr_pkg.sv
// ----------------------------------------------------------------------------
// sbfr_pkg: shared types and constants of the sprite blitter
// Opcodes, register indexes, fixed field widths and the control and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sbfr_pkg;

    localparam int DEF_MAX_SPRITE_W = 64;
    localparam int DEF_MAX_SPRITE_H = 64;

    localparam int SPR_AW   = 11;   // sprite byte address
    localparam int NIB_AW   = 12;   // sprite nibble address
    localparam int PAL_AW   = 4;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 11;
    localparam int COORD_W  = 10;
    localparam int COLOUR_W = 8;

    localparam logic [COORD_W-1:0] SCREEN_H_RESET = 10'd168;
    localparam logic [3:0]         NIBBLE_MASK    = 4'hF;

    typedef enum logic [1:0] {
        OP_LOAD_SPRITE  = 2'd0,
        OP_LOAD_PALETTE = 2'd1,
        OP_DRAW         = 2'd2
    } op_t;

    typedef enum logic [CFG_IW-1:0] {
        REG_ORIGIN_X      = 3'd0,
        REG_ORIGIN_Y      = 3'd1,
        REG_SPRITE_WIDTH  = 3'd2,
        REG_SPRITE_HEIGHT = 3'd3,
        REG_FLIP_MODE     = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_TRANSPARENT   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic setup;    // evaluate row clip and addressing terms
        logic issue;    // issue one column read
        logic finish;   // close the row and emit the final result
    } ctrl_cmd_t;

    typedef struct packed {
        logic row_visible;
        logic scan_done;
        logic flush_ready;
    } dp_status_t;

endpackage

// File: rtl/sbfr_ctrl.sv
// ----------------------------------------------------------------------------
// sbfr_ctrl: sequencer of the sprite blitter
// Takes one input transaction at a time and steps a draw through setup,
// column scan and final flush.
// ----------------------------------------------------------------------------
module sbfr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic [1:0]             op,
    input  sbfr_pkg::dp_status_t   status,
    output sbfr_pkg::ctrl_cmd_t    cmd,
    output logic                   in_stall
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SETUP,
        S_SCAN,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && (op == sbfr_pkg::OP_DRAW))
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                state_next = status.row_visible ? S_SCAN : S_FLUSH;
            end
            S_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (status.flush_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.accept = in_valid && (state_reg == S_IDLE);
    assign cmd.setup  = (state_reg == S_SETUP);
    assign cmd.issue  = (state_reg == S_SCAN) && !status.scan_done;
    assign cmd.finish = (state_reg == S_FLUSH) && status.flush_ready;

endmodule

// File: rtl/sbfr_datapath.sv
// ----------------------------------------------------------------------------
// sbfr_datapath: stores, clip and address unit, pixel pipe and result register
// Holds the configuration registers, the sprite byte memory and the palette,
// computes one nibble address per column, and keeps the latest opaque pixel
// pending so the final one can carry the last mark.
// ----------------------------------------------------------------------------
module sbfr_datapath #(
    parameter int MAX_SPRITE_W = sbfr_pkg::DEF_MAX_SPRITE_W,
    parameter int MAX_SPRITE_H = sbfr_pkg::DEF_MAX_SPRITE_H
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  sbfr_pkg::ctrl_cmd_t               cmd,
    output sbfr_pkg::dp_status_t              status,
    input  logic                              cfg_we,
    input  logic [sbfr_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [sbfr_pkg::CFG_DW-1:0]       cfg_data,
    input  logic [1:0]                        op,
    input  logic [10:0]                       addr,
    input  logic [7:0]                        data,
    input  logic [5:0]                        sprite_row,
    input  logic                              row_present,
    input  logic [9:0]                        row_min_x,
    input  logic [9:0]                        row_max_x,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              write,
    output logic [sbfr_pkg::COORD_W-1:0]      dest_x,
    output logic [sbfr_pkg::COORD_W-1:0]      dest_y,
    output logic [sbfr_pkg::COLOUR_W-1:0]     colour,
    output logic                              last
);

    localparam int WW = $clog2(MAX_SPRITE_W + 1);
    localparam int HW = $clog2(MAX_SPRITE_H + 1);
    localparam int NW = sbfr_pkg::NIB_AW;
    localparam int CW = sbfr_pkg::COORD_W;
    localparam int KW = sbfr_pkg::COLOUR_W;

    // configuration
    logic signed [10:0] origin_x_reg;
    logic signed [10:0] origin_y_reg;
    logic [6:0]         sprite_width_reg;
    logic [6:0]         sprite_height_reg;
    logic [2:0]         flip_mode_reg;
    logic [CW-1:0]      screen_height_reg;
    logic [3:0]         transparent_reg;

    // latched draw transaction
    logic [5:0]         row_reg;
    logic               present_reg;
    logic [9:0]         min_x_reg;
    logic [9:0]         max_x_reg;

    // row terms
    logic [WW-1:0]      i_reg;
    logic [WW-1:0]      end_reg;
    logic [CW-1:0]      y_reg;
    logic [NW-1:0]      a_row_reg;
    logic [NW-1:0]      c_row_reg;
    logic [WW-1:0]      b_reg;

    // read stage
    logic               v1_reg;
    logic [7:0]         rd_reg;
    logic               par1_reg;
    logic [CW-1:0]      x1_reg;

    // pending pixel and result register
    logic               pend_valid_reg;
    logic [CW-1:0]      pend_x_reg;
    logic [KW-1:0]      pend_colour_reg;
    logic               out_valid_reg;
    logic               write_reg;
    logic [CW-1:0]      dest_x_reg;
    logic [CW-1:0]      dest_y_reg;
    logic [KW-1:0]      colour_reg;
    logic               last_reg;

    logic [7:0]         sprite_mem [2**sbfr_pkg::SPR_AW];
    logic [KW-1:0]      pal_mem [2**sbfr_pkg::PAL_AW];

    logic               flip_x;
    logic               flip_y;
    logic               transpose;
    logic [WW-1:0]      w;
    logic [HW-1:0]      h;
    logic [NW-1:0]      w12;
    logic [NW-1:0]      h12;
    logic [NW-1:0]      j12;
    logic [NW-1:0]      i12;
    logic signed [11:0] y12;
    logic signed [12:0] ox13;
    logic signed [12:0] w13;
    logic signed [12:0] dlo;
    logic signed [12:0] dhi;
    logic signed [12:0] lo13;
    logic signed [12:0] hi13;
    logic               y_ok;
    logic [NW-1:0]      sj;
    logic [NW-1:0]      cj;
    logic [NW-1:0]      si;
    logic [NW-1:0]      ri;
    logic [NW-1:0]      a_sel;
    logic [NW-1:0]      c_sel;
    logic [2*NW-1:0]    prod;
    logic [NW-1:0]      nib;
    logic [CW-1:0]      col_x;
    logic [3:0]         nib_val;
    logic               opaque;
    logic               need_out;
    logic               out_free;
    logic               advance;
    logic               load_spr;
    logic               load_pal;

    assign flip_x    = flip_mode_reg[0];
    assign flip_y    = flip_mode_reg[1];
    assign transpose = flip_mode_reg[2];

    assign w = ({25'd0, sprite_width_reg} > MAX_SPRITE_W) ? WW'(MAX_SPRITE_W)
                                                          : WW'(sprite_width_reg);
    assign h = ({25'd0, sprite_height_reg} > MAX_SPRITE_H) ? HW'(MAX_SPRITE_H)
                                                           : HW'(sprite_height_reg);
    assign w12 = NW'(w);
    assign h12 = NW'(h);
    assign j12 = NW'(row_reg);
    assign i12 = NW'(i_reg);

    // vertical and horizontal clip
    assign y12  = $signed({origin_y_reg[10], origin_y_reg}) + $signed({6'd0, row_reg});
    assign y_ok = !y12[11] && (y12[10:0] < {1'b0, screen_height_reg});
    assign ox13 = $signed({{2{origin_x_reg[10]}}, origin_x_reg});
    assign w13  = $signed(13'(w));
    assign dlo  = $signed({3'd0, min_x_reg}) - ox13;
    assign dhi  = $signed({3'd0, max_x_reg}) + 13'sd1 - ox13;
    assign lo13 = (dlo > 13'sd0) ? dlo : 13'sd0;
    assign hi13 = (dhi < w13) ? dhi : w13;

    assign status.row_visible = present_reg && (j12 < h12) && y_ok && (lo13 < hi13);
    assign status.scan_done   = (i_reg == end_reg);

    // nibble address = A * B + C, modulo the nibble space
    assign sj    = flip_y ? (h12 - NW'(1) - j12) : j12;
    assign cj    = flip_x ? (w12 - NW'(1) - j12) : j12;
    assign si    = flip_x ? (w12 - NW'(1) - i12) : i12;
    assign ri    = flip_y ? (h12 - NW'(1) - i12) : i12;
    assign a_sel = transpose ? ri : a_row_reg;
    assign c_sel = transpose ? c_row_reg : si;
    assign prod  = a_sel * NW'(b_reg);
    assign nib   = prod[NW-1:0] + c_sel;
    assign col_x = origin_x_reg[CW-1:0] + CW'(i_reg);

    // pixel stage
    assign nib_val  = par1_reg ? (rd_reg[3:0] & sbfr_pkg::NIBBLE_MASK)
                               : (rd_reg[7:4] & sbfr_pkg::NIBBLE_MASK);
    assign opaque   = (nib_val != transparent_reg);
    assign need_out = v1_reg && opaque && pend_valid_reg;
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !need_out || out_free;

    assign status.flush_ready = !v1_reg && out_free;

    assign load_spr = cmd.accept && (op == sbfr_pkg::OP_LOAD_SPRITE);
    assign load_pal = cmd.accept && (op == sbfr_pkg::OP_LOAD_PALETTE) && (addr[10:4] == 7'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg      <= '0;
            origin_y_reg      <= '0;
            sprite_width_reg  <= '0;
            sprite_height_reg <= '0;
            flip_mode_reg     <= '0;
            screen_height_reg <= sbfr_pkg::SCREEN_H_RESET;
            transparent_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (sbfr_pkg::cfg_idx_t'(cfg_index))
                sbfr_pkg::REG_ORIGIN_X:      origin_x_reg      <= $signed(cfg_data[10:0]);
                sbfr_pkg::REG_ORIGIN_Y:      origin_y_reg      <= $signed(cfg_data[10:0]);
                sbfr_pkg::REG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data[6:0];
                sbfr_pkg::REG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data[6:0];
                sbfr_pkg::REG_FLIP_MODE:     flip_mode_reg     <= cfg_data[2:0];
                sbfr_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= cfg_data[CW-1:0];
                sbfr_pkg::REG_TRANSPARENT:   transparent_reg   <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // sprite memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (load_spr)
        begin
            sprite_mem[addr] <= data;
        end
        if (cmd.issue && advance)
        begin
            rd_reg <= sprite_mem[nib[NW-1:1]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_pal)
        begin
            pal_mem[addr[3:0]] <= data;
        end
    end

    // draw payload and row terms
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg     <= sprite_row;
            present_reg <= row_present;
            min_x_reg   <= row_min_x;
            max_x_reg   <= row_max_x;
        end
        if (cmd.setup)
        begin
            end_reg   <= hi13[WW-1:0];
            y_reg     <= y12[CW-1:0];
            a_row_reg <= sj;
            c_row_reg <= cj;
            b_reg     <= transpose ? {w[WW-1:1], 1'b0} : w;
        end
        if (cmd.issue && advance)
        begin
            par1_reg <= nib[0];
            x1_reg   <= col_x;
        end
        if (advance && v1_reg && opaque)
        begin
            pend_x_reg      <= x1_reg;
            pend_colour_reg <= pal_mem[nib_val];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
        end
        else if (cmd.setup)
        begin
            i_reg <= lo13[WW-1:0];
        end
        else if (cmd.issue && advance)
        begin
            i_reg <= i_reg + WW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            write_reg      <= 1'b0;
            dest_x_reg     <= '0;
            dest_y_reg     <= '0;
            colour_reg     <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                v1_reg <= cmd.issue;
            end
            if (cmd.finish || (advance && need_out))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept)
            begin
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.finish)
            begin
                pend_valid_reg <= 1'b0;
                write_reg      <= pend_valid_reg;
                dest_x_reg     <= pend_valid_reg ? pend_x_reg : '0;
                dest_y_reg     <= pend_valid_reg ? y_reg : '0;
                colour_reg     <= pend_valid_reg ? pend_colour_reg : '0;
                last_reg       <= 1'b1;
            end
            else if (advance && v1_reg && opaque)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    write_reg     <= 1'b1;
                    dest_x_reg    <= pend_x_reg;
                    dest_y_reg    <= y_reg;
                    colour_reg    <= pend_colour_reg;
                    last_reg      <= 1'b0;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign write     = write_reg;
    assign dest_x    = dest_x_reg;
    assign dest_y    = dest_y_reg;
    assign colour    = colour_reg;
    assign last      = last_reg;

`ifndef SYNTH
    a_issue_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (i_reg < end_reg))
        else $error("column read issued outside the clipped span");

    a_finish_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!v1_reg && out_free))
        else $error("row closed with a pixel still in the read stage");

    a_read_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && !advance) |=> (v1_reg && $stable(rd_reg) && $stable(par1_reg)))
        else $error("stalled read stage lost its data");

    a_mid_result_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> pend_valid_reg)
        else $error("non-final result without a pending pixel behind it");
`endif

endmodule

// File: rtl/sprite_blit_flip_rotate_unit.sv
// ----------------------------------------------------------------------------
// sprite_blit_flip_rotate_unit: 4-bit palettized sprite row blitter
// Loads sprite bytes and palette entries, then draws one clipped,
// flipped or transposed sprite row per draw transaction as pixel writes.
// ----------------------------------------------------------------------------
// One input transaction is taken at a time. A sprite or palette load is
// written while the unit stays idle, so loads do not hold off the input. A
// draw steps through a setup, one sprite memory read per column for the N
// columns left after clipping (at most MAX_SPRITE_W), a drain of the read
// stage and the closing result; stall on the result side can hold the scan
// and the closing result. The sprite memory read port sets the column rate.
// A draw with nothing visible gives a single result with write low; otherwise the final pixel write carries last.
module sprite_blit_flip_rotate_unit #(
    parameter int MAX_SPRITE_W = sbfr_pkg::DEF_MAX_SPRITE_W,
    parameter int MAX_SPRITE_H = sbfr_pkg::DEF_MAX_SPRITE_H
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sbfr_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [sbfr_pkg::CFG_DW-1:0]       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        op,
    input  logic [10:0]                       addr,
    input  logic [7:0]                        data,
    input  logic [5:0]                        sprite_row,
    input  logic                              row_present,
    input  logic [9:0]                        row_min_x,
    input  logic [9:0]                        row_max_x,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              write,
    output logic [sbfr_pkg::COORD_W-1:0]      dest_x,
    output logic [sbfr_pkg::COORD_W-1:0]      dest_y,
    output logic [sbfr_pkg::COLOUR_W-1:0]     colour,
    output logic                              last
);

    sbfr_pkg::ctrl_cmd_t  cmd;
    sbfr_pkg::dp_status_t status;

    sbfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    sbfr_datapath #(
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .op          (op),
        .addr        (addr),
        .data        (data),
        .sprite_row  (sprite_row),
        .row_present (row_present),
        .row_min_x   (row_min_x),
        .row_max_x   (row_max_x),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .write       (write),
        .dest_x      (dest_x),
        .dest_y      (dest_y),
        .colour      (colour),
        .last        (last)
    );

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for sprite_blit_flip_rotate_unit
// Loads sprite bytes and palette entries, draws clipped, mirrored and
// transposed rows under several register settings, and compares every
// pixel-write transaction with the rows predicted from a shadow of both stores.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W = sbfr_pkg::DEF_MAX_SPRITE_W;
    localparam int MAX_H = sbfr_pkg::DEF_MAX_SPRITE_H;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRAIN = MAX_W + 16;
    localparam int HOLD = 400;
    localparam int LIMIT = 1000000;

    typedef struct {
        logic [1:0] op;
        logic [10:0] addr;
        logic [7:0] data;
        logic [5:0] row;
        logic present;
        logic [9:0] min_x;
        logic [9:0] max_x;
    } blit_req_t;

    typedef struct packed {
        logic wr;
        logic [9:0] x;
        logic [9:0] y;
        logic [7:0] colour;
        logic last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [sbfr_pkg::CFG_IW-1:0] cfg_index = '0;
    logic [sbfr_pkg::CFG_DW-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [1:0] op = '0;
    logic [10:0] addr = '0;
    logic [7:0] data = '0;
    logic [5:0] sprite_row = '0;
    logic row_present = 1'b0;
    logic [9:0] row_min_x = '0;
    logic [9:0] row_max_x = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic write;
    logic [sbfr_pkg::COORD_W-1:0] dest_x;
    logic [sbfr_pkg::COORD_W-1:0] dest_y;
    logic [sbfr_pkg::COLOUR_W-1:0] colour;
    logic last;

    // register mirror, shared by stimulus shaping and prediction
    logic signed [10:0] org_x = '0;
    logic signed [10:0] org_y = '0;
    logic [6:0] spr_w = '0;
    logic [6:0] spr_h = '0;
    logic [2:0] flip = '0;
    logic [9:0] scr_h = sbfr_pkg::SCREEN_H_RESET;
    logic [3:0] key_index = '0;

    // predictor stores, updated on accepted transactions
    logic [7:0] sprite_mem [2048];
    logic [7:0] palette_mem [16];

    // stimulus-side shadow, updated as transactions are queued
    logic [7:0] shadow_sprite [2048];
    bit sprite_seen [2048];
    bit palette_seen [16];

    blit_req_t txn_q[$];
    blit_req_t cur_req;
    pixel_t pixel_exp_q[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    logic hold_req = 1'b0;
    logic hold_used = 1'b0;
    int hold_left = 0;
    int unsigned cycle_count = 0;

    int errors = 0;
    int n_draw = 0;
    int n_pix = 0;
    int n_blank = 0;
    int n_load = 0;
    int n_setting = 0;
    int n_queued = 0;

    sprite_blit_flip_rotate_unit uut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic int eff_w();
        return (spr_w > MAX_W) ? MAX_W : int'(spr_w);
    endfunction

    function automatic int eff_h();
        return (spr_h > MAX_H) ? MAX_H : int'(spr_h);
    endfunction

    function automatic int clip_col(input int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // column range [i0, i1) and destination row; returns whether the row is present, inside the sprite and on screen
    function automatic bit row_span(input int j, input bit present, input int lo_x,
                                    input int hi_x, output int i0, output int i1,
                                    output int y);
        int ox;
        ox = org_x;
        y = int'(org_y) + j;
        i0 = 0;
        i1 = eff_w();
        if (ox < lo_x)
            i0 = lo_x - ox;
        if (ox + i1 > hi_x + 1)
            i1 = hi_x + 1 - ox;
        return present && j < eff_h() && y >= 0 && y < int'(scr_h);
    endfunction

    function automatic void column_fetch(input int j, input int i,
                                         output logic [10:0] byte_addr, output bit low);
        logic [31:0] c;
        logic [31:0] r;
        logic [31:0] n;
        int w;
        int h;
        w = eff_w();
        h = eff_h();
        if (flip[2])
        begin
            c = flip[0] ? w - 1 - j : j;
            r = flip[1] ? h - 1 - i : i;
            n = r * (w >> 1) + (c >> 1);
            byte_addr = n[10:0];
            low = c[0];
        end
        else
        begin
            n = (flip[1] ? h - 1 - j : j) * w + (flip[0] ? w - 1 - i : i);
            byte_addr = n[11:1];
            low = n[0];
        end
    endfunction

    task automatic expect_pixels(input blit_req_t t);
        int i0;
        int i1;
        int y;
        int xi;
        logic [10:0] ba;
        bit low;
        logic [7:0] b;
        logic [3:0] v;
        pixel_t held;
        bit have;
        have = 0;
        held = '0;
        case (t.op)
            sbfr_pkg::OP_LOAD_SPRITE:
            begin
                sprite_mem[t.addr] = t.data;
                n_load++;
            end
            sbfr_pkg::OP_LOAD_PALETTE:
            begin
                if (t.addr < 16)
                    palette_mem[t.addr[3:0]] = t.data;
                n_load++;
            end
            sbfr_pkg::OP_DRAW:
            begin
                n_draw++;
                if (row_span(t.row, t.present, t.min_x, t.max_x, i0, i1, y))
                begin
                    for (int i = i0; i < i1; i++)
                    begin
                        column_fetch(t.row, i, ba, low);
                        b = sprite_mem[ba];
                        v = low ? b[3:0] : b[7:4];
                        if (v != key_index)
                        begin
                            if (have)
                                pixel_exp_q.push_back(held);
                            xi = int'(org_x) + i;
                            held.wr = 1'b1;
                            held.x = xi[9:0];
                            held.y = y[9:0];
                            held.colour = palette_mem[v];
                            held.last = 1'b0;
                            have = 1;
                            n_pix++;
                        end
                    end
                end
                if (!have)
                    n_blank++;
                held.last = 1'b1;
                pixel_exp_q.push_back(held);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input bit has_want,
                                   input pixel_t want, input pixel_t got);
        errors++;
        if (errors <= 10)
        begin
            if (has_want)
                $display("%s: expected wr=%0d x=%0d y=%0d colour=%02h last=%0d",
                         what, want.wr, want.x, want.y, want.colour, want.last);
            $display("%s: got wr=%0d x=%0d y=%0d colour=%02h last=%0d",
                     what, got.wr, got.x, got.y, got.colour, got.last);
        end
    endtask

    task automatic check_pixel(input pixel_t got);
        pixel_t want;
        if (pixel_exp_q.size() == 0)
        begin
            report_mismatch("unexpected pixel transaction", 0, '0, got);
        end
        else
        begin
            want = pixel_exp_q.pop_front();
            if (got.wr !== want.wr || got.x !== want.x || got.y !== want.y ||
                got.colour !== want.colour || got.last !== want.last)
                report_mismatch("pixel mismatch", 1, want, got);
        end
    endtask

    function automatic blit_req_t rand_req();
        blit_req_t t;
        t.op = 2'($urandom);
        t.addr = 11'($urandom);
        t.data = 8'($urandom);
        t.row = 6'($urandom);
        t.present = 1'($urandom);
        t.min_x = 10'($urandom);
        t.max_x = 10'($urandom);
        return t;
    endfunction

    task automatic push_req(input blit_req_t t);
        txn_q.push_back(t);
        n_queued++;
        if (t.op == sbfr_pkg::OP_LOAD_SPRITE)
        begin
            shadow_sprite[t.addr] = t.data;
            sprite_seen[t.addr] = 1;
        end
        else if (t.op == sbfr_pkg::OP_LOAD_PALETTE && t.addr < 16)
        begin
            palette_seen[t.addr[3:0]] = 1;
        end
    endtask

    task automatic push_sprite(input logic [10:0] a, input logic [7:0] d);
        blit_req_t t;
        t = rand_req();
        t.op = sbfr_pkg::OP_LOAD_SPRITE;
        t.addr = a;
        t.data = d;
        push_req(t);
    endtask

    task automatic push_palette(input logic [10:0] a, input logic [7:0] d);
        blit_req_t t;
        t = rand_req();
        t.op = sbfr_pkg::OP_LOAD_PALETTE;
        t.addr = a;
        t.data = d;
        push_req(t);
    endtask

    // load whatever the row will read that has never been written, then draw it
    task automatic push_draw(input int j, input bit present, input int lo_x, input int hi_x);
        blit_req_t t;
        int i0;
        int i1;
        int y;
        logic [10:0] ba;
        bit low;
        logic [3:0] v;
        if (row_span(j, present, lo_x, hi_x, i0, i1, y))
        begin
            for (int i = i0; i < i1; i++)
            begin
                column_fetch(j, i, ba, low);
                if (!sprite_seen[ba])
                    push_sprite(ba, 8'($urandom));
                v = low ? shadow_sprite[ba][3:0] : shadow_sprite[ba][7:4];
                if (v != key_index && !palette_seen[v])
                    push_palette(11'(v), 8'($urandom));
            end
        end
        t = rand_req();
        t.op = sbfr_pkg::OP_DRAW;
        t.row = 6'(j);
        t.present = present;
        t.min_x = 10'(lo_x);
        t.max_x = 10'(hi_x);
        push_req(t);
    endtask

    task automatic random_phase(input int n);
        blit_req_t t;
        int start;
        int roll;
        int w;
        int h;
        int j;
        int ox;
        int lo_x;
        int hi_x;
        start = n_queued;
        w = eff_w();
        h = eff_h();
        ox = org_x;
        while (n_queued - start < n)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
            begin
                push_sprite(11'($urandom), 8'($urandom));
            end
            else if (roll < 13)
            begin
                push_palette(11'($urandom_range(0, 31)), 8'($urandom));
            end
            else if (roll < 17)
            begin
                t = rand_req();
                t.op = OP_UNUSED;
                push_req(t);
            end
            else
            begin
                if (h > 0 && $urandom_range(0, 99) < 85)
                    j = $urandom_range(0, h - 1);
                else
                    j = $urandom_range(0, 63);
                if ($urandom_range(0, 9) < 6)
                begin
                    lo_x = clip_col(ox - 4 + int'($urandom_range(0, w / 2 + 4)));
                    hi_x = clip_col(ox + w + 3 - int'($urandom_range(0, w / 2 + 4)));
                end
                else
                begin
                    lo_x = $urandom_range(0, 1023);
                    hi_x = $urandom_range(0, 1023);
                end
                push_draw(j, $urandom_range(0, 9) != 0, lo_x, hi_x);
            end
        end
    endtask

    task automatic cfg_write(input sbfr_pkg::cfg_idx_t idx, input int val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 11'(val);
        case (idx)
            sbfr_pkg::REG_ORIGIN_X: org_x = 11'(val);
            sbfr_pkg::REG_ORIGIN_Y: org_y = 11'(val);
            sbfr_pkg::REG_SPRITE_WIDTH: spr_w = 7'(val);
            sbfr_pkg::REG_SPRITE_HEIGHT: spr_h = 7'(val);
            sbfr_pkg::REG_FLIP_MODE: flip = 3'(val);
            sbfr_pkg::REG_SCREEN_HEIGHT: scr_h = 10'(val);
            sbfr_pkg::REG_TRANSPARENT: key_index = 4'(val);
            default: ;
        endcase
    endtask

    task automatic cfg_close();
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input int ox, input int oy, input int w, input int h,
                            input int f, input int sh, input int key);
        cfg_write(sbfr_pkg::REG_ORIGIN_X, ox);
        cfg_write(sbfr_pkg::REG_ORIGIN_Y, oy);
        cfg_write(sbfr_pkg::REG_SPRITE_WIDTH, w);
        cfg_write(sbfr_pkg::REG_SPRITE_HEIGHT, h);
        cfg_write(sbfr_pkg::REG_FLIP_MODE, f);
        cfg_write(sbfr_pkg::REG_SCREEN_HEIGHT, sh);
        cfg_write(sbfr_pkg::REG_TRANSPARENT, key);
        cfg_close();
        n_setting++;
    endtask

    task automatic random_regs();
        int w;
        int h;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 127) : $urandom_range(0, 64);
        set_regs(int'($urandom_range(0, 1069)) - 70, int'($urandom_range(0, 300)) - 40,
                 w, h, $urandom_range(0, 7),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023) : $urandom_range(100, 1023),
                 $urandom_range(0, 15));
    endtask

    task automatic set_pace(input int s, input int r);
        @(posedge clk);
        send_idle_pct <= s;
        recv_idle_pct <= r;
    endtask

    task automatic wait_drained();
        while (txn_q.size() != 0 || in_valid || pixel_exp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                expect_pixels(cur_req);
            if (!in_valid || !in_stall)
            begin
                if (txn_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    cur_req = txn_q.pop_front();
                    in_valid <= 1'b1;
                    op <= cur_req.op;
                    addr <= cur_req.addr;
                    data <= cur_req.data;
                    sprite_row <= cur_req.row;
                    row_present <= cur_req.present;
                    row_min_x <= cur_req.min_x;
                    row_max_x <= cur_req.max_x;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_req && !hold_used)
        begin
            hold_left <= HOLD;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_pixel({write, dest_x, dest_y, colour, last});
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT)
        begin
            $display("sprite_blit_flip_rotate_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        blit_req_t t;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        set_pace(15, 77);

        // reset settings: zero-size sprite, unused opcode, out-of-range palette load
        t = rand_req();
        t.op = OP_UNUSED;
        t.addr = '1;
        t.data = '1;
        t.row = '1;
        t.present = 1'b1;
        t.min_x = '1;
        t.max_x = '1;
        push_req(t);
        push_palette(11'h7FF, 8'hFF);
        push_draw(0, 1, 0, 1023);
        wait_drained();

        set_regs(0, 0, 16, 8, 0, 168, 0);
        push_sprite(11'h7FF, 8'h00);
        push_draw(0, 1, 0, 1023);
        push_draw(7, 1, 3, 9);
        push_draw(8, 1, 0, 1023);
        push_draw(63, 1, 0, 1023);
        push_draw(2, 0, 0, 1023);
        push_draw(1, 1, 10, 5);
        push_draw(5, 1, 1023, 1023);
        for (int k = 0; k < 8; k++)
            push_sprite(11'(24 + k), 8'h00);
        push_draw(3, 1, 0, 1023);
        push_palette(11'd15, 8'hFF);
        push_sprite(11'd0, 8'hFF);
        push_draw(0, 1, 0, 1023);
        wait_drained();

        for (int f = 1; f < 8; f++)
        begin
            cfg_write(sbfr_pkg::REG_FLIP_MODE, f);
            cfg_close();
            push_draw(f, 1, 0, 1023);
            wait_drained();
        end

        set_regs(-1024, 1023, 64, 64, 7, 1023, 15);
        random_phase(12);
        wait_drained();
        set_regs(1023, -1024, 0, 0, 0, 0, 0);
        random_phase(12);
        wait_drained();
        set_regs(960, 1000, 127, 100, 3, 1023, 15);
        random_phase(50);
        @(posedge clk);
        hold_req <= 1'b1;
        wait_drained();
        set_regs(-10, -5, 1, 1, 5, 168, 0);
        random_phase(30);
        wait_drained();

        set_pace(77, 15);
        set_regs(3, 2, 4, 40, 4, 200, 7);
        random_phase(40);
        wait_drained();
        set_regs(100, 50, 33, 17, 6, 168, 9);
        random_phase(40);
        wait_drained();
        for (int p = 0; p < 2; p++)
        begin
            random_regs();
            random_phase(40);
            wait_drained();
        end

        set_pace(0, 0);
        for (int p = 0; p < 4; p++)
        begin
            random_regs();
            random_phase(40);
            wait_drained();
        end

        $display("Covered %0d draws (%0d pixel writes, %0d blank rows) and %0d loads",
                 n_draw, n_pix, n_blank, n_load);
        $display("over %0d register settings, all flip modes, clipping and a %0d-cycle hold-off",
                 n_setting, HOLD);
        if (errors == 0)
            $display("sprite_blit_flip_rotate_unit: match");
        else
            $display("sprite_blit_flip_rotate_unit: mismatch");
        $finish;
    end

endmodule

// File: files.f
rtl/sbfr_pkg.sv
rtl/sbfr_ctrl.sv
rtl/sbfr_datapath.sv
rtl/sprite_blit_flip_rotate_unit.sv
bench/tb_top.sv
